FILE: rtl/pgf_pkg.sv
// Shared types, constants and step functions of the pairwise gravity force unit.
`default_nettype none

package pgf_pkg;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned NUM_W      = 98;
  localparam int unsigned FORCE_W    = 48;

  localparam logic [31:0] G_RESET = 32'd171799;
  localparam logic [FORCE_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [FORCE_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [63:0]        rem;
    logic [DIV_STEPS-1:0] low;
    logic [DIV_STEPS-1:0] quo;
    logic               ovf;
  } div_lane_t;

  // one digit-by-digit square root step, b is the current power of four
  function automatic sq_t sqrt_step(sq_t s, logic [63:0] b);
    sq_t         o;
    logic [63:0] trial;
    trial = s.r + b;
    o = s;
    if (s.v >= trial) begin
      o.v = s.v - trial;
      o.r = (s.r >> 1) + b;
    end else begin
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // one restoring division step: shift in next dividend bit, compare, subtract
  function automatic div_lane_t div_step(div_lane_t l, logic [63:0] d);
    div_lane_t   o;
    logic [64:0] t;
    logic [64:0] diff;
    t = {l.rem, l.low[DIV_STEPS-1]};
    diff = t - {1'b0, d};
    o = l;
    o.low = {l.low[DIV_STEPS-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      o.rem = diff[63:0];
      o.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.rem = t[63:0];
      o.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pgf_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
`default_nettype none

module pgf_isqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [63:0]       radicand,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [31:0]            root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int unsigned N = pgf_pkg::SQRT_STEPS;

  pgf_pkg::sq_t      st  [0:N];
  logic              vld [0:N];
  logic [SIDE_W-1:0] sd  [0:N];

  assign st[0].v = radicand;
  assign st[0].r = 64'd0;
  assign vld[0]  = in_valid;
  assign sd[0]   = in_side;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= pgf_pkg::sqrt_step(st[k], BIT);
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = st[N].r[31:0];
  assign out_side  = sd[N];

endmodule

`default_nettype wire

FILE: rtl/pgf_div.sv
// Two-lane pipelined restoring divider sharing one divisor, with overflow detect.
`default_nettype none

module pgf_div #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [pgf_pkg::NUM_W-1:0]    num_x,
  input  wire logic [pgf_pkg::NUM_W-1:0]    num_y,
  input  wire logic [63:0]                  den,
  input  wire logic [SIDE_W-1:0]            in_side,
  output logic                              out_valid,
  output logic [pgf_pkg::DIV_STEPS-1:0]     quo_x,
  output logic [pgf_pkg::DIV_STEPS-1:0]     quo_y,
  output logic                              ovf_x,
  output logic                              ovf_y,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int unsigned N  = pgf_pkg::DIV_STEPS;
  localparam int unsigned HW = pgf_pkg::NUM_W - N;

  pgf_pkg::div_lane_t lx  [0:N];
  pgf_pkg::div_lane_t ly  [0:N];
  logic [63:0]        dq  [0:N];
  logic               vld [0:N];
  logic [SIDE_W-1:0]  sd  [0:N];

  // quotient fits 48 bits only if the high dividend part is below the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx[0].rem <= 64'(num_x[pgf_pkg::NUM_W-1:N]);
      lx[0].low <= num_x[N-1:0];
      lx[0].quo <= '0;
      lx[0].ovf <= 64'(num_x[pgf_pkg::NUM_W-1:N]) >= den;
      ly[0].rem <= 64'(num_y[pgf_pkg::NUM_W-1:N]);
      ly[0].low <= num_y[N-1:0];
      ly[0].quo <= '0;
      ly[0].ovf <= 64'(num_y[pgf_pkg::NUM_W-1:N]) >= den;
      dq[0]     <= den;
      sd[0]     <= in_side;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lx[k+1] <= pgf_pkg::div_step(lx[k], dq[k]);
        ly[k+1] <= pgf_pkg::div_step(ly[k], dq[k]);
        dq[k+1] <= dq[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign quo_x     = lx[N].quo;
  assign quo_y     = ly[N].quo;
  assign ovf_x     = lx[N].ovf;
  assign ovf_y     = ly[N].ovf;
  assign out_side  = sd[N];

  if (HW == 0) begin : g_bad_width
    $error("dividend must be wider than the quotient");
  end

endmodule

`default_nettype wire

FILE: rtl/pairwise_gravity_force_unit.sv
// Top level: pairwise gravity force of two bodies, one pair per clock unless stalled.
//
//  channel   dir  fields (tdata from bit 0 up)
//  s_axis    in   first_x[15:0] first_y[31:16] second_x[47:32] second_y[63:48]
//                 first_mass[87:64] second_mass[111:88] first_radius[123:112]
//                 second_radius[135:124]
//  m_axis    out  tdata: force_x[47:0] force_y[95:48]; tuser: touching[0] saturated[1]
//  cfg       in   cfg_wen / cfg_wdata: gravity constant, unsigned Q0.32
//
// One pair per cycle sustained while the output is not stalled; the pipeline has 4 front
// stages, 32 square root stages, one S*T multiply, 49 divider stages, output register.
// The divider chain sets the depth: one quotient bit per stage.
// rst clears all valid bits and loads the gravity constant with its default.
// A stalled output freezes the whole pipeline; s_axis_tready follows.
`default_nettype none

module pairwise_gravity_force_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,   // first_x, first_y, second_x, second_y,
                                            // first_mass, second_mass, first_radius,
                                            // second_radius
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,   // force_x, force_y
  output logic [1:0]        m_axis_tuser,   // touching, saturated
  input  wire logic         cfg_wen,
  input  wire logic [31:0]  cfg_wdata
);

  localparam int unsigned NW       = pgf_pkg::NUM_W;
  localparam int unsigned FW       = pgf_pkg::FORCE_W;
  localparam int unsigned SQ_SIDE  = 2 * NW + 3 + 33;

  logic        en;
  logic [31:0] gravity;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= pgf_pkg::G_RESET;
    end else if (cfg_wen) begin
      gravity <= cfg_wdata;
    end
  end

  // stage A: differences, magnitudes, radius sum, mass product
  logic signed [16:0] dx, dy;
  logic [16:0]        dx_mag, dy_mag;
  logic [47:0]        mass_prod;

  assign dx = 17'(signed'(s_axis_tdata[15:0])) - 17'(signed'(s_axis_tdata[47:32]));
  assign dy = 17'(signed'(s_axis_tdata[31:16])) - 17'(signed'(s_axis_tdata[63:48]));
  assign dx_mag = dx[16] ? 17'(-dx) : 17'(dx);
  assign dy_mag = dy[16] ? 17'(-dy) : 17'(dy);
  assign mass_prod = {24'd0, s_axis_tdata[87:64]} * {24'd0, s_axis_tdata[111:88]};

  logic        a_v;
  logic [15:0] a_ax, a_ay;
  logic        a_negx, a_negy;
  logic [12:0] a_rsum;
  logic [47:0] a_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ax   <= dx_mag[15:0];
      a_ay   <= dy_mag[15:0];
      a_negx <= dx[16];
      a_negy <= dy[16];
      a_rsum <= {1'b0, s_axis_tdata[123:112]} + {1'b0, s_axis_tdata[135:124]};
      a_p    <= mass_prod;
    end
  end

  // stage B: squared distance, squared radius sum, G times each delta
  logic [31:0] sqx, sqy;
  logic [25:0] rr_w;
  logic [47:0] gx_w, gy_w;

  assign sqx  = {16'd0, a_ax} * {16'd0, a_ax};
  assign sqy  = {16'd0, a_ay} * {16'd0, a_ay};
  assign rr_w = {13'd0, a_rsum} * {13'd0, a_rsum};
  assign gx_w = {16'd0, gravity} * {32'd0, a_ax};
  assign gy_w = {16'd0, gravity} * {32'd0, a_ay};

  logic        b_v;
  logic [32:0] b_s;
  logic [25:0] b_rr;
  logic [47:0] b_gx, b_gy, b_p;
  logic        b_negx, b_negy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_s    <= {1'b0, sqx} + {1'b0, sqy};
      b_rr   <= rr_w;
      b_gx   <= gx_w;
      b_gy   <= gy_w;
      b_p    <= a_p;
      b_negx <= a_negx;
      b_negy <= a_negy;
    end
  end

  // stage C: touch test, numerator partial products
  logic        c_v;
  logic [32:0] c_s;
  logic        c_touch;
  logic [71:0] c_nxl, c_nxh, c_nyl, c_nyh;
  logic        c_negx, c_negy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_s     <= b_s;
      c_touch <= (b_s == 33'd0) || (b_s < {7'd0, b_rr});
      c_nxl   <= {24'd0, b_gx} * {48'd0, b_p[23:0]};
      c_nxh   <= {24'd0, b_gx} * {48'd0, b_p[47:24]};
      c_nyl   <= {24'd0, b_gy} * {48'd0, b_p[23:0]};
      c_nyh   <= {24'd0, b_gy} * {48'd0, b_p[47:24]};
      c_negx  <= b_negx;
      c_negy  <= b_negy;
    end
  end

  // stage D: full numerators, times the distance scale of four
  logic [95:0] nx_sum, ny_sum;

  assign nx_sum = {c_nxh, 24'd0} + {24'd0, c_nxl};
  assign ny_sum = {c_nyh, 24'd0} + {24'd0, c_nyl};

  logic          d_v;
  logic [NW-1:0] d_nx, d_ny;
  logic [32:0]   d_s;
  logic          d_touch, d_negx, d_negy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_nx    <= {nx_sum, 2'b00};
      d_ny    <= {ny_sum, 2'b00};
      d_s     <= c_s;
      d_touch <= c_touch;
      d_negx  <= c_negx;
      d_negy  <= c_negy;
    end
  end

  // distance in Q.14: sqrt(S * 2^28)
  logic               sq_v;
  logic [31:0]        sq_root;
  logic [SQ_SIDE-1:0] sq_side;

  pgf_isqrt #(
    .SIDE_W (SQ_SIDE)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_v),
    .radicand  ({3'd0, d_s, 28'd0}),
    .in_side   ({d_nx, d_ny, d_negx, d_negy, d_touch, d_s}),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  logic [NW-1:0] q_nx, q_ny;
  logic          q_negx, q_negy, q_touch;
  logic [32:0]   q_s;
  logic [63:0]   c_prod;

  // S*T stays below 2^64 over the whole input range
  assign {q_nx, q_ny, q_negx, q_negy, q_touch, q_s} = sq_side;
  assign c_prod = {31'd0, q_s} * {32'd0, sq_root};

  // stage E: divisor C = S * T
  logic          e_v;
  logic [63:0]   e_c;
  logic [NW-1:0] e_nx, e_ny;
  logic          e_negx, e_negy, e_touch;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_c     <= c_prod;
      e_nx    <= q_nx;
      e_ny    <= q_ny;
      e_negx  <= q_negx;
      e_negy  <= q_negy;
      e_touch <= q_touch;
    end
  end

  logic          dv_v;
  logic [FW-1:0] dv_qx, dv_qy;
  logic          dv_ovfx, dv_ovfy;
  logic [2:0]    dv_side;

  pgf_div #(
    .SIDE_W (3)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_v),
    .num_x     (e_nx),
    .num_y     (e_ny),
    .den       (e_c),
    .in_side   ({e_negx, e_negy, e_touch}),
    .out_valid (dv_v),
    .quo_x     (dv_qx),
    .quo_y     (dv_qy),
    .ovf_x     (dv_ovfx),
    .ovf_y     (dv_ovfy),
    .out_side  (dv_side)
  );

  // sign and clip; returns {clipped, value}
  function automatic logic [FW:0] shape(logic [FW-1:0] q, logic ovf, logic neg);
    logic clip;
    if (neg) begin
      clip = ovf || (q > pgf_pkg::NEG_LIMIT);
      return {clip, clip ? pgf_pkg::NEG_LIMIT : FW'(0) - q};
    end else begin
      clip = ovf || q[FW-1];
      return {clip, clip ? pgf_pkg::POS_LIMIT : q};
    end
  endfunction

  logic [FW:0] fx, fy;

  assign fx = shape(dv_qx, dv_ovfx, dv_side[2]);
  assign fy = shape(dv_qy, dv_ovfy, dv_side[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_side[0]) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 2'b01;
      end else begin
        m_axis_tdata <= {fy[FW-1:0], fx[FW-1:0]};
        m_axis_tuser <= {fx[FW] || fy[FW], 1'b0};
      end
    end
  end

  a_touch_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("touching result carries force or clip flag");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tdata[47:0] == pgf_pkg::POS_LIMIT || m_axis_tdata[47:0] == pgf_pkg::NEG_LIMIT ||
      m_axis_tdata[95:48] == pgf_pkg::POS_LIMIT || m_axis_tdata[95:48] == pgf_pkg::NEG_LIMIT)
    else $error("clip flag without a clipped component");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid && !a_v)
    else $error("valid survived reset");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> a_v)
    else $error("accepted transfer lost at pipeline entry");

endmodule

`default_nettype wire

FILE: tb/sv/pairwise_gravity_force_unit_checker.sv
// Checker for the pairwise gravity force unit: predicts each pair's force and compares.
module pairwise_gravity_force_unit_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           forces_pending,
  output int           forces_seen,
  output int           touch_seen,
  output int           clip_seen
);

  localparam int TOUCH_BIT = 0;
  localparam int CLIP_BIT  = 1;

  typedef struct packed {
    logic [pgf_pkg::FORCE_W-1:0] fx;
    logic [pgf_pkg::FORCE_W-1:0] fy;
    logic                        touch;
    logic                        clip;
  } force_t;

  logic [31:0] grav_g;
  force_t      force_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one force component, magnitude truncated toward zero and clipped by sign
  function automatic logic [pgf_pkg::FORCE_W-1:0] axis_force(logic signed [16:0] delta,
      logic [31:0] g, logic [23:0] m1, logic [23:0] m2, logic [63:0] c, ref logic clip);
    logic [16:0]  mag;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] lim;
    mag = delta < 0 ? -delta : delta;
    lim = delta < 0 ? {80'd0, pgf_pkg::NEG_LIMIT} : {80'd0, pgf_pkg::POS_LIMIT};
    num = 128'(g) * 128'(m1) * 128'(m2) * (128'(mag) * 128'd4);
    q = num / ((c == 0) ? 128'd1 : 128'(c));
    if (q > lim) begin
      q = lim;
      clip = 1'b1;
    end
    return delta < 0 ? pgf_pkg::FORCE_W'(-q) : pgf_pkg::FORCE_W'(q);
  endfunction

  function automatic force_t pair_force(logic [135:0] d, logic [31:0] g);
    force_t            f;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]       ax;
    logic [16:0]       ay;
    logic [35:0]       s;
    logic [12:0]       rsum;
    logic [63:0]       t;
    logic [63:0]       c;
    logic              clip;
    dx = $signed(d[15:0]) - $signed(d[47:32]);
    dy = $signed(d[31:16]) - $signed(d[63:48]);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s = 36'(ax) * 36'(ax) + 36'(ay) * 36'(ay);
    rsum = 13'(d[123:112]) + 13'(d[135:124]);
    f = '0;
    if (s == 0 || s < 36'(rsum) * 36'(rsum)) begin
      f.touch = 1'b1;
      return f;
    end
    t = int_sqrt({s, 28'd0});
    c = 64'(s) * t;  // wraps to 64 bits like the divider operand
    clip = 1'b0;
    f.fx = axis_force(dx, g, d[87:64], d[111:88], c, clip);
    f.fy = axis_force(dy, g, d[87:64], d[111:88], c, clip);
    f.clip = clip;
    return f;
  endfunction

  assign forces_pending = force_q.size();

  always @(posedge clk) begin
    force_t exp_f;
    force_t got;
    if (rst) begin
      grav_g <= pgf_pkg::G_RESET;
      force_q.delete();
      fail_count <= 0;
      forces_seen <= 0;
      touch_seen <= 0;
      clip_seen <= 0;
    end else begin
      if (cfg_wen) grav_g <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        force_q.insert(force_q.size(), pair_force(s_axis_tdata, grav_g));
      if (m_axis_tvalid && m_axis_tready) begin
        got.fx = m_axis_tdata[47:0];
        got.fy = m_axis_tdata[95:48];
        got.touch = m_axis_tuser[TOUCH_BIT];
        got.clip = m_axis_tuser[CLIP_BIT];
        forces_seen <= forces_seen + 1;
        touch_seen <= touch_seen + got.touch;
        clip_seen <= clip_seen + got.clip;
        if (force_q.size() == 0) begin
          $display("%0t: unexpected result fx=%h fy=%h touch=%b sat=%b",
                   $time, got.fx, got.fy, got.touch, got.clip);
          fail_count <= fail_count + 1;
        end else begin
          exp_f = force_q.pop_front();
          if (got.fx !== exp_f.fx)
            $display("%0t: force_x expected %h actual %h", $time, exp_f.fx, got.fx);
          if (got.fy !== exp_f.fy)
            $display("%0t: force_y expected %h actual %h", $time, exp_f.fy, got.fy);
          if (got.touch !== exp_f.touch)
            $display("%0t: touching expected %b actual %b", $time, exp_f.touch, got.touch);
          if (got.clip !== exp_f.clip)
            $display("%0t: saturated expected %b actual %b", $time, exp_f.clip, got.clip);
          if (got !== exp_f) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

FILE: tb/sv/pairwise_gravity_force_unit_tb.sv
// Testbench top: drives body pairs and G settings, judges via the checker.
module pairwise_gravity_force_unit_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int PAIRS_PER_G = 260;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_wen = 0;
  logic [31:0]  cfg_wdata = '0;

  int fail_count, forces_pending, forces_seen, touch_seen, clip_seen;
  int stall_cycles = 0;
  int hold_cycles = 0;
  int pairs_sent = 0;
  bit no_gaps = 0;

  pairwise_gravity_force_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  pairwise_gravity_force_unit_checker u_check (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .forces_pending(forces_pending),
    .forces_seen(forces_seen), .touch_seen(touch_seen), .clip_seen(clip_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver backpressure, with a long stall now and then
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (!no_gaps && $urandom_range(0, 299) == 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= $urandom_range(20, 60);
    end else if (no_gaps || r < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [135:0] pack_pair(logic [15:0] x1, logic [15:0] y1,
      logic [15:0] x2, logic [15:0] y2, logic [23:0] m1, logic [23:0] m2,
      logic [11:0] r1, logic [11:0] r2);
    return {r2, r1, m2, m1, y2, x2, y1, x1};
  endfunction

  task automatic send_pair(logic [135:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    pairs_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (forces_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_g(logic [31:0] g);
    cfg_wen <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [135:0] random_pair();
    logic [15:0] x1, y1, x2, y2;
    logic [23:0] m1, m2;
    logic [11:0] r1, r2;
    int          sh;
    int          kind;
    kind = $urandom_range(0, 9);
    x1 = $urandom; y1 = $urandom;
    sh = $urandom_range(0, 15);
    x2 = x1 + (16'($urandom) >>> sh);
    y2 = y1 + (16'($urandom) >>> $urandom_range(0, 15));
    if (kind >= 7) begin
      x2 = $urandom; y2 = $urandom;
    end
    m1 = 24'($urandom) >> $urandom_range(0, 24);
    m2 = 24'($urandom) >> $urandom_range(0, 24);
    r1 = 12'($urandom) >> $urandom_range(0, 12);
    r2 = 12'($urandom) >> $urandom_range(0, 12);
    if (kind == 9) begin  // near contact
      r1 = 12'($urandom_range(0, 40));
      r2 = 12'($urandom_range(0, 40));
      x2 = x1 + 16'($urandom_range(0, 60)) - 16'd30;
      y2 = y1 + 16'($urandom_range(0, 60)) - 16'd30;
    end
    return pack_pair(x1, y1, x2, y2, m1, m2, r1, r2);
  endfunction

  initial begin
    logic [31:0] g_set[7];
    g_set = '{pgf_pkg::G_RESET, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0001_0000, 32'h8000_0000,
              32'd0};
    g_set[6] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: coincident, contact boundary, extremes, zero mass, axis-aligned
    send_pair(pack_pair(16'd5, 16'd5, 16'd5, 16'd5, 24'd10, 24'd10, 12'd0, 12'd0));
    send_pair(pack_pair(16'd3, 16'd4, 16'd0, 16'd0, 24'd100, 24'd100, 12'd2, 12'd3));
    send_pair(pack_pair(16'd3, 16'd4, 16'd0, 16'd0, 24'd100, 24'd100, 12'd3, 12'd3));
    send_pair(pack_pair(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 24'hFFFFFF, 24'hFFFFFF,
                        12'hFFF, 12'hFFF));
    send_pair(pack_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF,
                        12'd0, 12'd0));
    send_pair(pack_pair(16'd1, 16'd0, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 12'd0, 12'd0));
    send_pair(pack_pair(16'd0, 16'd0, 16'd0, 16'd1, 24'hFFFFFF, 24'hFFFFFF, 12'd0, 12'd0));
    send_pair(pack_pair(16'd0, 16'd0, 16'd40, 16'd0, 24'd0, 24'hFFFFFF, 12'd1, 12'd1));
    send_pair(pack_pair(16'd0, 16'd0, 16'd0, 16'hFFC0, 24'd7, 24'd0, 12'd1, 12'd1));
    send_pair(pack_pair(16'h7FFF, 16'd0, 16'h8000, 16'd0, 24'd1, 24'd1, 12'd0, 12'd0));
    send_pair(pack_pair(16'd0, 16'h8000, 16'd0, 16'h7FFF, 24'd1, 24'd1, 12'hFFF, 12'hFFF));
    send_pair(pack_pair(16'd100, 16'hFF9C, 16'hFF9C, 16'd100, 24'd5000, 24'd9000,
                        12'd10, 12'd20));
    send_pair(pack_pair(16'd2, 16'd2, 16'd0, 16'd0, 24'hFFFFFF, 24'd1, 12'd0, 12'd0));

    foreach (g_set[i]) begin
      drain();
      write_g(g_set[i]);
      for (int k = 0; k < PAIRS_PER_G; k++) begin
        no_gaps = (k >= 100 && k < 140);
        send_pair(random_pair());
      end
      no_gaps = 0;
    end
    drain();

    $display("%0d pairs over %0d G settings: %0d results, %0d touching, %0d saturated",
             pairs_sent, 7, forces_seen, touch_seen, clip_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
